// File: sv/isfd_pkg.sv
// Types, codes and scaling constants shared by the serial frame decoder.
package isfd_pkg;

   localparam int FrameLen = 11;
   localparam logic [3:0] LastPos = 4'(FrameLen - 1);
   localparam int RawLastByte = FrameLen - 2;

   localparam logic [7:0] HeaderByte = 8'h55;
   localparam logic [7:0] KindAccelByte = 8'h51;
   localparam logic [7:0] KindGyroByte = 8'h52;
   localparam logic [7:0] KindAngleByte = 8'h53;

   typedef logic [1:0] kind_type;
   localparam kind_type KindAccel = 2'd0;
   localparam kind_type KindGyro = 2'd1;
   localparam kind_type KindAngle = 2'd2;

   typedef logic signed [15:0] raw_type;
   typedef logic signed [27:0] axis_type;
   typedef logic signed [24:0] temp_type;

   // full-scale gains times 2^16 / 32768
   localparam logic [11:0] GainAccel = 12'd32;
   localparam logic [11:0] GainGyro = 12'd4000;
   localparam logic [11:0] GainAngle = 12'd360;

   // |raw| * 65536 / 340 == |raw| * 2^14 / 85, done as a reciprocal multiply
   localparam int TempRecipShift = 37;
   localparam int TempShift = TempRecipShift - 14;
   localparam logic [30:0] TempRecip =
      31'(((64'd1 << TempRecipShift) + 64'd84) / 64'd85);
   localparam temp_type TempOffset = 25'sd2375680;

   typedef struct packed {
      kind_type kind;
      raw_type raw_x;
      raw_type raw_y;
      raw_type raw_z;
      raw_type raw_t;
   } frame_type;

   function automatic logic [11:0] axis_gain(input kind_type kind);
      logic [11:0] gain;
      unique case (kind)
         KindAccel: gain = GainAccel;
         KindGyro: gain = GainGyro;
         KindAngle: gain = GainAngle;
         default: gain = GainAccel;
      endcase
      return gain;
   endfunction

   function automatic axis_type axis_scale(input raw_type raw, input logic [11:0] gain);
      logic signed [31:0] a;
      logic signed [31:0] b;
      logic signed [31:0] p;
      a = 32'(raw);
      b = $signed({20'd0, gain});
      p = a * b;
      return p[27:0];
   endfunction

endpackage

// File: sv/isfd_if.sv
// Byte and result channel interfaces of the serial frame decoder.
interface isfd_req_if;
   logic valid;
   logic ready;
   logic [7:0] rx_byte;
   modport source(output valid, output rx_byte, input ready);
   modport sink(input valid, input rx_byte, output ready);
endinterface

interface isfd_rsp_if import isfd_pkg::*; ();
   logic valid;
   logic ready;
   kind_type frame_kind;
   axis_type axis_x;
   axis_type axis_y;
   axis_type axis_z;
   temp_type temperature;
   modport source(output valid, output frame_kind, output axis_x, output axis_y,
                  output axis_z, output temperature, input ready);
   modport sink(input valid, input frame_kind, input axis_x, input axis_y,
                input axis_z, input temperature, output ready);
endinterface

// File: sv/imu_serial_frame_decoder.sv
// Top level of the IMU serial frame decoder.
// Takes one received serial byte per beat, at up to one beat per clock, and
// frames 11-byte packets that open with header 0x55; other bytes at the start
// are dropped. Each complete packet of kind 0x51, 0x52 or 0x53 yields one
// result beat with the kind, three axes and temperature in signed fixed point
// with 16 fractional bits; other kinds and the checksum byte are ignored. The
// result beat is presented from the result register behind a multiply stage,
// both of them registered; the byte side stalls only while
// both of those hold beats the result side has not taken.
module imu_serial_frame_decoder import isfd_pkg::*; (
   input  logic clock,
   input  logic reset,
   isfd_req_if.sink req_bus,
   isfd_rsp_if.source rsp_bus
);

   logic accept;
   logic frame_valid;
   logic scaler_ready;
   frame_type frame;

   assign req_bus.ready = scaler_ready;
   assign accept = req_bus.valid && scaler_ready;

   isfd_framer u_framer (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .rx_byte(req_bus.rx_byte),
      .frame_valid(frame_valid),
      .frame(frame)
   );

   isfd_scaler u_scaler (
      .clock(clock),
      .reset(reset),
      .in_valid(frame_valid),
      .frame(frame),
      .in_ready(scaler_ready),
      .rsp(rsp_bus)
   );

endmodule

// File: sv/isfd_framer.sv
// Packet framer: tracks byte position, stores payload bytes, flags complete frames of a known kind.
module isfd_framer import isfd_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic accept,
   input  logic [7:0] rx_byte,
   output logic frame_valid,
   output frame_type frame
);

   logic [3:0] pos_ff, pos_in;
   logic [7:0] byte_ff [1:RawLastByte];
   logic kind_ok;

   always_comb begin
      priority if (pos_ff == 4'd0) begin
         pos_in = (rx_byte == HeaderByte) ? 4'd1 : 4'd0;
      end else if (pos_ff == LastPos) begin
         pos_in = 4'd0;
      end else begin
         pos_in = pos_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= 4'd0;
      end else if (accept) begin
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 1; i <= RawLastByte; i++) begin
         if (accept && pos_ff == 4'(i)) begin
            byte_ff[i] <= rx_byte;
         end
      end
   end

   always_comb begin
      kind_ok = 1'b1;
      frame.kind = KindAccel;
      unique case (byte_ff[1])
         KindAccelByte: frame.kind = KindAccel;
         KindGyroByte: frame.kind = KindGyro;
         KindAngleByte: frame.kind = KindAngle;
         default: kind_ok = 1'b0;
      endcase
      frame.raw_x = {byte_ff[3], byte_ff[2]};
      frame.raw_y = {byte_ff[5], byte_ff[4]};
      frame.raw_z = {byte_ff[7], byte_ff[6]};
      frame.raw_t = {byte_ff[9], byte_ff[8]};
   end

   assign frame_valid = accept && (pos_ff == LastPos) && kind_ok;

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= LastPos) else $error("frame position past last byte");

   a_pos_wrap: assert property (@(posedge clock) disable iff (reset)
      accept && pos_ff == LastPos |=> pos_ff == 4'd0)
      else $error("position did not wrap after last byte");

   a_header_drop: assert property (@(posedge clock) disable iff (reset)
      accept && pos_ff == 4'd0 && rx_byte != HeaderByte |=> pos_ff == 4'd0)
      else $error("non-header byte started a frame");

endmodule

// File: sv/isfd_scaler.sv
// Two-stage fixed-point scaler with the result register.
module isfd_scaler import isfd_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  frame_type frame,
   output logic in_ready,
   isfd_rsp_if.source rsp
);

   logic a_valid_ff;
   kind_type a_kind_ff;
   axis_type a_x_ff, a_y_ff, a_z_ff;
   logic [22:0] a_tmag_ff, a_tmag_in;
   logic a_tneg_ff;

   logic out_valid_ff;
   kind_type out_kind_ff;
   axis_type out_x_ff, out_y_ff, out_z_ff;
   temp_type out_temp_ff, out_temp_in;

   logic [11:0] gain;
   logic [15:0] t_abs;
   logic [46:0] t_prod;
   temp_type t_mag;

   logic out_load, a_load;

   assign out_load = !out_valid_ff || rsp.ready;
   assign a_load = !a_valid_ff || out_load;
   assign in_ready = a_load;

   always_comb begin
      gain = axis_gain(frame.kind);
      t_abs = frame.raw_t[15] ? 16'(-frame.raw_t) : 16'(frame.raw_t);
      t_prod = 47'(t_abs) * 47'(TempRecip);
      a_tmag_in = t_prod[TempShift + 22:TempShift];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_load) begin
         a_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (a_load && in_valid) begin
         a_kind_ff <= frame.kind;
         a_x_ff <= axis_scale(frame.raw_x, gain);
         a_y_ff <= axis_scale(frame.raw_y, gain);
         a_z_ff <= axis_scale(frame.raw_z, gain);
         a_tmag_ff <= a_tmag_in;
         a_tneg_ff <= frame.raw_t[15];
      end
   end

   always_comb begin
      t_mag = $signed({2'b00, a_tmag_ff});
      out_temp_in = (a_tneg_ff ? -t_mag : t_mag) + TempOffset;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load && a_valid_ff) begin
         out_kind_ff <= a_kind_ff;
         out_x_ff <= a_x_ff;
         out_y_ff <= a_y_ff;
         out_z_ff <= a_z_ff;
         out_temp_ff <= out_temp_in;
      end
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.frame_kind = out_kind_ff;
   assign rsp.axis_x = out_x_ff;
   assign rsp.axis_y = out_y_ff;
   assign rsp.axis_z = out_z_ff;
   assign rsp.temperature = out_temp_ff;

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      in_valid |-> in_ready) else $error("frame offered while stage full");

   a_temp_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_temp_ff >= -25'sd3940448 && out_temp_ff <= 25'sd8691615)
      else $error("temperature out of range");

   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_kind_ff != 2'd3) else $error("illegal frame kind");

   a_stage_flow: assert property (@(posedge clock) disable iff (reset)
      a_valid_ff && out_load |=> out_valid_ff)
      else $error("stage beat lost on the way to the result register");

endmodule

// File: test/imu_serial_frame_decoder_tb.sv
// Self-checking bench for the IMU serial frame decoder: byte stream in, scaled frame results out.
module imu_serial_frame_decoder_tb import isfd_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [7:0] NoKindByte = 8'h54;
   localparam int HoldCycles = 300;
   localparam int PhaseBytes = 220;
   localparam int PressureBytes = 130;

   typedef struct packed {
      kind_type kind;
      axis_type x;
      axis_type y;
      axis_type z;
      temp_type t;
   } frame_result_type;

   typedef struct {
      int len;
      logic [10:0][7:0] bytes;
      bit pinned;
      frame_result_type want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   isfd_req_if req_bus();
   isfd_rsp_if rsp_bus();

   imu_serial_frame_decoder dut (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   always #4 clock = ~clock;

   // decoder state mirror
   logic [3:0] frame_pos = '0;
   logic [7:0] frame_buf [0:10] = '{default: 8'h00};

   frame_result_type expected_frames[$];
   frame_result_type pinned_result;
   bit pin_next = 1'b0;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   bit rsp_hold_request = 1'b0;
   int rsp_hold_left = 0;

   int errors = 0;
   int bytes_sent = 0;
   int results_seen = 0;
   int kind_count [0:2] = '{0, 0, 0};

   stim_row_type stim_rows [0:5];

   function automatic bit decode_byte(input logic [7:0] b, output frame_result_type r);
      int unsigned p;
      longint gain;
      raw_type rx, ry, rz, rt;
      longint temp_full;
      r = '0;
      p = (frame_pos >= LastPos) ? LastPos : frame_pos;
      frame_buf[p] = b;
      if (p == 0 && b != HeaderByte)
         return 1'b0;
      if (p < LastPos) begin
         frame_pos = 4'(p + 1);
         return 1'b0;
      end
      frame_pos = '0;
      case (frame_buf[1])
         KindAccelByte: begin
            r.kind = KindAccel;
            gain = 32;
         end
         KindGyroByte: begin
            r.kind = KindGyro;
            gain = 4000;
         end
         KindAngleByte: begin
            r.kind = KindAngle;
            gain = 360;
         end
         default: return 1'b0;
      endcase
      rx = {frame_buf[3], frame_buf[2]};
      ry = {frame_buf[5], frame_buf[4]};
      rz = {frame_buf[7], frame_buf[6]};
      rt = {frame_buf[9], frame_buf[8]};
      r.x = axis_type'(longint'(rx) * gain);
      r.y = axis_type'(longint'(ry) * gain);
      r.z = axis_type'(longint'(rz) * gain);
      // signed division truncates toward zero
      temp_full = longint'(rt) * 65536 / 340 + 2375680;
      r.t = temp_type'(temp_full);
      return 1'b1;
   endfunction

   function automatic logic [10:0][7:0] pack_frame(input logic [7:0] kind_byte,
         input logic [15:0] x, input logic [15:0] y, input logic [15:0] z,
         input logic [15:0] t, input logic [7:0] chk);
      return {chk, t[15:8], t[7:0], z[15:8], z[7:0], y[15:8], y[7:0],
              x[15:8], x[7:0], kind_byte, HeaderByte};
   endfunction

   function automatic logic [15:0] pick_raw();
      case ($urandom_range(19))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic void check_field(input string name, input longint want,
         input longint got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         errors++;
      end
   endfunction

   task automatic send_byte(input logic [7:0] b);
      frame_result_type r;
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.rx_byte <= b;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      bytes_sent++;
      if (decode_byte(b, r)) begin
         if (pin_next)
            r = pinned_result;
         expected_frames.push_back(r);
      end
   endtask

   // mostly whole packets; some stray bytes and cut-short packets
   task automatic send_random_burst();
      logic [10:0][7:0] f;
      logic [7:0] kb;
      int n;
      int pick;
      pick = $urandom_range(99);
      case ($urandom_range(9))
         0: kb = 8'($urandom);
         1, 2, 3: kb = KindAccelByte;
         4, 5, 6: kb = KindGyroByte;
         default: kb = KindAngleByte;
      endcase
      f = pack_frame(kb, pick_raw(), pick_raw(), pick_raw(), pick_raw(), 8'($urandom));
      if (pick < 8) begin
         n = 1;
         f[0] = 8'($urandom);
      end else if (pick < 16) begin
         n = $urandom_range(2, 10);
      end else begin
         n = 11;
      end
      for (int i = 0; i < n; i++)
         send_byte(f[i]);
   endtask

   // result side: random stalls plus one long hold-off on request
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            rsp_hold_left--;
         end else if (rsp_hold_request) begin
            rsp_hold_request = 1'b0;
            rsp_hold_left = HoldCycles - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      frame_result_type got;
      frame_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = {rsp_bus.frame_kind, rsp_bus.axis_x, rsp_bus.axis_y, rsp_bus.axis_z,
                rsp_bus.temperature};
         if (expected_frames.size() == 0) begin
            $display("%0t: unexpected result beat, expected none, got kind %0d x %0d",
                     $time, got.kind, got.x);
            errors++;
         end else begin
            want = expected_frames.pop_front();
            results_seen++;
            if (want.kind <= KindAngle)
               kind_count[want.kind]++;
            check_field("frame_kind", want.kind, got.kind);
            check_field("axis_x", want.x, got.x);
            check_field("axis_y", want.y, got.y);
            check_field("axis_z", want.z, got.z);
            check_field("temperature", want.t, got.t);
         end
      end
   end

   initial begin
      int send_plan [0:3];
      int stall_plan [0:3];
      int mark;
      send_plan = '{0, 68, 0, 27};
      stall_plan = '{0, 0, 68, 27};

      // bad header bytes, including a kind byte out of place
      stim_rows[0] = '{3, 88'({KindAccelByte, 8'hFF, 8'h00}), 1'b0, '0};
      stim_rows[1] = '{11, pack_frame(KindAccelByte, 16'h8000, 16'h7FFF, 16'h0000,
                       16'h0000, 8'h00), 1'b1,
                       '{KindAccel, -28'sd1048576, 28'sd1048544, 28'sd0, 25'sd2375680}};
      stim_rows[2] = '{11, pack_frame(KindGyroByte, 16'h7FFF, 16'h8000, 16'h0001,
                       16'h0000, 8'hFF), 1'b1,
                       '{KindGyro, 28'sd131068000, -28'sd131072000, 28'sd4000,
                         25'sd2375680}};
      stim_rows[3] = '{11, pack_frame(KindAngleByte, 16'hFFFF, 16'h8000, 16'h7FFF,
                       16'h8000, 8'h55), 1'b0, '0};
      // unknown kind: no result
      stim_rows[4] = '{11, pack_frame(NoKindByte, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                       16'hFFFF, 8'h00), 1'b0, '0};
      // checksum ignored
      stim_rows[5] = '{11, pack_frame(KindAccelByte, 16'h0001, 16'hFFFF, 16'h1234,
                       16'h7FFF, 8'hAA), 1'b0, '0};

      req_bus.valid <= 1'b0;
      req_bus.rx_byte <= 8'h00;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_rows[r]) begin
         for (int i = 0; i < stim_rows[r].len; i++) begin
            pin_next = stim_rows[r].pinned && (i == stim_rows[r].len - 1);
            pinned_result = stim_rows[r].want;
            send_byte(stim_rows[r].bytes[i]);
         end
      end
      pin_next = 1'b0;

      for (int p = 0; p < 4; p++) begin
         send_idle_pct = send_plan[p];
         rsp_stall_pct = stall_plan[p];
         mark = bytes_sent;
         while (bytes_sent - mark < PhaseBytes)
            send_random_burst();
      end

      // back-pressure: receiver holds off while bytes keep coming
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      rsp_hold_request = 1'b1;
      mark = bytes_sent;
      while (bytes_sent - mark < PressureBytes)
         send_random_burst();
      req_bus.valid <= 1'b0;

      while (expected_frames.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Sent %0d bytes; checked %0d frames (accel %0d, rate %0d, angle %0d).",
               bytes_sent, results_seen, kind_count[0], kind_count[1], kind_count[2]);
      $display("Covered stray and cut-short packets, unknown kinds, idle/stall mixes "
               , "and a long result hold-off.");
      if (errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin
      #5ms;
      $display("%0t: timeout, %0d results still expected", $time, expected_frames.size());
      $display("TB_ERROR");
      $finish;
   end

endmodule
